// ===== rtl/core/smt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smt_pkg
// Types and constants shared by the controller and datapath of the sorted
// multiset table.
// ----------------------------------------------------------------------------
package smt_pkg;

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;
  // The spare action code behaves as a query.
  localparam logic [1:0] ACT_SPARE  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_SATURATED = 2'd3;

  localparam int unsigned AMOUNT_WIDTH = 8;
  localparam int unsigned TOTAL_WIDTH  = 22;
  localparam int unsigned OUT_COUNT_WIDTH = 16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // Capture the input word and start a walk at the head.
    logic rd_node;   // Issue a read of the current node.
    logic rd_free;   // Issue a read of the free-list head's link.
    logic step;      // Evaluate the node read data and advance.
    logic finish;    // Apply the update and form the result.
  } smt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk_done; // No more nodes to visit.
    logic hit;       // The node just read holds the value.
    logic busy;      // The link table is still being initialized.
  } smt_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/smt_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smt_datapath
// Node tables, list pointers, walk registers and result formation.
// ----------------------------------------------------------------------------
module smt_datapath #(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire smt_pkg::smt_cmd_t   cmd,
  output smt_pkg::smt_stat_t       stat,
  input  wire logic                order_mode,
  input  wire logic [1:0]          action,
  input  wire logic signed [31:0]  element_value,
  input  wire logic [7:0]          amount,
  output logic                     found,
  output logic [15:0]              occurrences,
  output logic [21:0]              total_size,
  output logic [1:0]               status
);
  import smt_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY) + 1;
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam logic [IW-1:0] NIL = IW'(CAPACITY);
  localparam logic [COUNT_WIDTH-1:0] CMAX = '1;
  localparam int unsigned SW = (COUNT_WIDTH > AMOUNT_WIDTH) ? COUNT_WIDTH + 1
                                                            : AMOUNT_WIDTH + 1;

  logic [VALUE_WIDTH-1:0] value_mem [CAPACITY];
  logic [COUNT_WIDTH-1:0] count_mem [CAPACITY];
  logic [IW-1:0]          link_mem  [CAPACITY];

  logic [VALUE_WIDTH-1:0] rd_value;
  logic [COUNT_WIDTH-1:0] rd_count;
  logic [IW-1:0]          rd_link;
  logic [AW-1:0]          rd_addr;

  logic [1:0]             act;
  logic [VALUE_WIDTH-1:0] val;
  logic [7:0]             amt;
  logic [IW-1:0]          cur, last, prev, pred, node;
  logic [IW-1:0]          prev_link, node_next;
  logic [IW-1:0]          list_head, free_head;
  logic [AW:0]            steps;
  logic [COUNT_WIDTH-1:0] cnt;
  logic                   is_found;
  logic [TOTAL_WIDTH-1:0] total;

  // Link table reset sweep: entry i links i+1.
  logic                   init_busy;
  logic [AW:0]            init_idx;

  logic                   key_before;
  logic [VALUE_WIDTH-1:0] ka, kb;
  logic                   link_we;
  logic [AW-1:0]          link_wa;
  logic [IW-1:0]          link_wd;
  logic                   data_we;
  logic [AW-1:0]          data_wa;
  logic [VALUE_WIDTH-1:0] value_wd;
  logic [COUNT_WIDTH-1:0] count_wd;
  logic                   link2_we;
  logic [AW-1:0]          link2_wa;
  logic [IW-1:0]          link2_wd;

  logic [SW-1:0]          room, add;
  logic                   sat;

  always_comb begin
    ka = rd_value ^ {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    kb = val ^ {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    key_before = order_mode ? (ka > kb) : (ka < kb);
  end

  assign stat.walk_done = (cur >= NIL) || (steps >= (AW+1)'(CAPACITY));
  assign stat.hit = (rd_value == val);
  assign stat.busy = init_busy;

  // The one read port serves the walk and the free-list link fetch.
  assign rd_addr = cmd.rd_free ? free_head[AW-1:0] : cur[AW-1:0];

  always_comb begin
    room = SW'(CMAX) - SW'(is_found ? cnt : '0);
    add  = SW'(amt);
    sat  = 1'b0;
    if (add > room) begin
      add = room;
      sat = 1'b1;
    end
  end

  // Update writes at finish; the link table takes up to two writes over
  // two ports, which stay on distinct entries. Links needed here were
  // captured during the walk or by the free-list fetch.
  always_comb begin
    link_we = 1'b0; link_wa = '0; link_wd = '0;
    link2_we = 1'b0; link2_wa = '0; link2_wd = '0;
    data_we = 1'b0; data_wa = '0; value_wd = val; count_wd = '0;
    if (cmd.finish) begin
      if (act == ACT_ADD && amt != '0) begin
        if (is_found) begin
          data_we = 1'b1; data_wa = node[AW-1:0];
          value_wd = val; count_wd = cnt + add[COUNT_WIDTH-1:0];
        end else if (free_head < NIL) begin
          data_we = 1'b1; data_wa = free_head[AW-1:0];
          count_wd = add[COUNT_WIDTH-1:0];
          link_we = 1'b1; link_wa = free_head[AW-1:0];
          link_wd = (prev < NIL) ? prev_link : list_head;
          if (prev < NIL) begin
            link2_we = 1'b1; link2_wa = prev[AW-1:0]; link2_wd = free_head;
          end
        end
      end else if (act == ACT_REMOVE && is_found) begin
        data_we = 1'b1; data_wa = node[AW-1:0];
        count_wd = (cnt > 1) ? cnt - 1'b1 : '0;
        if (cnt <= 1) begin
          link_we = 1'b1; link_wa = node[AW-1:0]; link_wd = free_head;
          if (pred < NIL) begin
            link2_we = 1'b1; link2_wa = pred[AW-1:0]; link2_wd = node_next;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_node || cmd.rd_free) begin
      rd_value <= value_mem[rd_addr];
      rd_count <= count_mem[rd_addr];
      rd_link  <= link_mem[rd_addr];
    end
    if (data_we) begin
      value_mem[data_wa] <= value_wd;
      count_mem[data_wa] <= count_wd;
    end
    if (init_busy) begin
      link_mem[init_idx[AW-1:0]] <= IW'(init_idx) + 1'b1;
    end else begin
      if (link_we)  link_mem[link_wa]  <= link_wd;
      if (link2_we) link_mem[link2_wa] <= link2_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_busy <= 1'b1;
      init_idx  <= '0;
      list_head <= NIL;
      free_head <= '0;
      total     <= '0;
      found     <= 1'b0;
      occurrences <= '0;
      total_size  <= '0;
      status      <= ST_OK;
      cur <= NIL; steps <= '0;
    end else begin
      if (init_busy) begin
        init_idx <= init_idx + 1'b1;
        if (init_idx == (AW+1)'(CAPACITY - 1)) init_busy <= 1'b0;
      end
      if (cmd.load) begin
        act <= action; amt <= amount;
        val <= VALUE_WIDTH'(signed'(element_value));
        cur <= list_head; last <= NIL; prev <= NIL; pred <= NIL; node <= NIL;
        steps <= '0; is_found <= 1'b0; cnt <= '0;
      end
      if (cmd.step) begin
        if (stat.hit) begin
          is_found <= 1'b1; node <= cur; pred <= last; cnt <= rd_count;
          node_next <= rd_link;
          cur <= NIL;
        end else begin
          if (key_before) begin
            prev <= cur;
            prev_link <= rd_link;
          end
          last <= cur; cur <= rd_link; steps <= steps + 1'b1;
        end
      end
      if (cmd.finish) begin
        found <= is_found;
        status <= ST_OK;
        occurrences <= OUT_COUNT_WIDTH'(cnt);
        if (act == ACT_ADD) begin
          if (amt != '0) begin
            if (is_found) begin
              occurrences <= OUT_COUNT_WIDTH'(cnt + add[COUNT_WIDTH-1:0]);
              total <= total + TOTAL_WIDTH'(add);
              total_size <= total + TOTAL_WIDTH'(add);
              if (sat) status <= ST_SATURATED;
            end else if (free_head >= NIL) begin
              status <= ST_FULL;
              total_size <= total;
            end else begin
              occurrences <= OUT_COUNT_WIDTH'(add[COUNT_WIDTH-1:0]);
              total <= total + TOTAL_WIDTH'(add);
              total_size <= total + TOTAL_WIDTH'(add);
              if (sat) status <= ST_SATURATED;
              free_head <= rd_link;
              if (prev >= NIL) list_head <= free_head;
            end
          end else begin
            total_size <= total;
          end
        end else if (act == ACT_REMOVE) begin
          if (!is_found) begin
            status <= ST_NOT_FOUND;
            total_size <= total;
          end else begin
            occurrences <= OUT_COUNT_WIDTH'((cnt > 1) ? cnt - 1'b1 : '0);
            total <= (total != '0) ? total - 1'b1 : total;
            total_size <= (total != '0) ? total - 1'b1 : total;
            if (cnt <= 1) begin
              free_head <= node;
              if (pred >= NIL) list_head <= node_next;
            end
          end
        end else begin
          total_size <= total;
          if (!is_found) status <= ST_NOT_FOUND;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/smt_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smt_ctrl
// Sequencer for one operation: accept, walk the list, update, deliver.
// ----------------------------------------------------------------------------
module smt_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output smt_pkg::smt_cmd_t       cmd,
  input  wire smt_pkg::smt_stat_t stat
);
  import smt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_READ, S_EVAL, S_FREE, S_FINISH
  } state_t;
  state_t state;

  // The input is taken only when idle and nothing is held; the finished
  // word waits in the output register.
  assign in_stall = (state != S_IDLE) || out_valid;

  always_comb begin
    cmd = '0;
    cmd.load    = (state == S_IDLE) && in_valid && !out_valid;
    cmd.rd_node = (state == S_READ);
    cmd.rd_free = (state == S_FREE);
    cmd.step    = (state == S_EVAL);
    cmd.finish  = (state == S_FINISH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE:   if (cmd.load) state <= S_CHECK;
        S_CHECK: begin
          // Hold here until the link table sweep after reset is over.
          if (!stat.busy) state <= stat.walk_done ? S_FREE : S_READ;
        end
        S_READ:   state <= S_EVAL;
        S_EVAL:   state <= S_CHECK;
        S_FREE:   state <= S_FINISH;
        S_FINISH: begin
          state <= S_IDLE;
          out_valid <= 1'b1;
        end
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/sorted_multiset_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_multiset_table
// Sorted bag of signed values with counts, kept as a linked list in a table.
// ----------------------------------------------------------------------------
// Usage: an input word (action, element_value, amount) is taken when in_valid
// is high and in_stall low. The block walks the list one node at a time
// (check, memory read, compare), then reads the free-list head's link,
// updates the tables and loads the result word (found, occurrences,
// total_size, status) into an output register, shown with out_valid until
// taken with out_stall low. One operation is in flight at a time, as the
// input stalls until the sequencer is back in idle with no result held, and
// the next word can be taken in the cycle after the result word leaves.
// After reset the link table is swept to its initial chain, one entry a
// cycle; an operation taken meanwhile waits in the walk check until the
// sweep ends. order_mode is to be written through cfg_we/cfg_data only
// while idle; the block itself does not enforce it. A stalled result is
// held and no new word is taken.
// ----------------------------------------------------------------------------
module sorted_multiset_table #(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic               cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         action,
  input  wire logic signed [31:0] element_value,
  input  wire logic [7:0]         amount,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    found,
  output logic [15:0]             occurrences,
  output logic [21:0]             total_size,
  output logic [1:0]              status
);
  import smt_pkg::*;

  logic      order_mode;
  smt_cmd_t  cmd;
  smt_stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      order_mode <= 1'b0;
    end else if (cfg_we) begin
      order_mode <= cfg_data;
    end
  end

  smt_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .cmd, .stat
  );

  smt_datapath #(
    .CAPACITY(CAPACITY), .VALUE_WIDTH(VALUE_WIDTH), .COUNT_WIDTH(COUNT_WIDTH)
  ) u_dp (
    .clk, .rst, .cmd, .stat, .order_mode, .action, .element_value, .amount,
    .found, .occurrences, .total_size, .status
  );

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("word accepted while result held");
  a_found_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |-> (status != ST_NOT_FOUND))
    else $error("found result reports not found");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found && status == ST_NOT_FOUND) |-> (occurrences == '0))
    else $error("missing value reports a count");
`endif

endmodule
`default_nettype wire
